[rtl/core/smcd_pkg.sv]
// Shared types, constants and CRC/UDRE helper functions for the SBAS message checker.
package smcd_pkg;

    // CRC-24Q generator without its implied x^24 term.
    localparam logic [23:0] CRC_POLY = 24'h864CFB;
    localparam logic [5:0]  FULL_BYTES = 6'd32;
    localparam logic [7:0]  PRN_BASE = 8'd120;

    localparam logic [5:0] TYPE_FC2 = 6'd2;
    localparam logic [5:0] TYPE_FC3 = 6'd3;
    localparam logic [5:0] TYPE_FC4 = 6'd4;
    localparam logic [5:0] TYPE_FC6 = 6'd6;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_SHORT = 2'd1,
        STATUS_CRC_FAIL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         msg_type;
        logic               fc_valid;
        logic [7:0]         sat_prn;
        logic signed [11:0] range_corr;
        logic [8:0]         udre_quarter_m;
    } t_out_item;

    // One classified message handed from the front end to the decoder.
    typedef struct packed {
        logic        is_short;
        logic        crc_ok;
        logic [5:0]  type_f;
        logic [5:0]  slot_f;
        logic [11:0] corr_f;
        logic [3:0]  udrei_f;
    } t_job;

    function automatic logic [23:0] crc_bit(input logic [23:0] c, input logic b);
        logic [23:0] s;
        s = {c[22:0], 1'b0} ^ (c[23] ? CRC_POLY : 24'h000000);
        return s ^ {23'd0, b};
    endfunction

    function automatic logic [23:0] crc_byte(input logic [23:0] c, input logic [7:0] d);
        logic [23:0] s;
        s = c;
        for (int k = 7; k >= 0; k--) begin
            s = crc_bit(s, d[k]);
        end
        return s;
    endfunction

    // UDREI to UDRE in quarter meters.
    function automatic logic [8:0] udre_lut(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd3;
            4'd1:    v = 9'd4;
            4'd2:    v = 9'd5;
            4'd3:    v = 9'd7;
            4'd4:    v = 9'd9;
            4'd5:    v = 9'd12;
            4'd6:    v = 9'd15;
            4'd7:    v = 9'd18;
            4'd8:    v = 9'd21;
            4'd9:    v = 9'd24;
            4'd10:   v = 9'd30;
            4'd11:   v = 9'd60;
            default: v = 9'd400;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/smcd_stream_if.sv]
// Valid/ready stream interface carrying one payload beat.
interface smcd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/smcd_front.sv]
// Front end: per-byte CRC update, field capture and message classification.
module smcd_front
    import smcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    smcd_stream_if.sink   i_in,
    input  logic          i_q_full,
    output logic          o_q_push,
    output t_job          o_q_job
);

    localparam logic [5:0] BYTE_TYPE  = 6'd1;
    localparam logic [5:0] BYTE_SLOT  = 6'd2;
    localparam logic [5:0] BYTE_CORR0 = 6'd5;
    localparam logic [5:0] BYTE_CORR1 = 6'd6;
    localparam logic [5:0] BYTE_CORR2 = 6'd7;
    localparam logic [5:0] BYTE_LAST_DATA = 6'd27;
    localparam logic [5:0] BYTE_CRC0  = 6'd28;
    localparam logic [5:0] BYTE_CRC1  = 6'd29;
    localparam logic [5:0] BYTE_CRC2  = 6'd30;
    localparam logic [5:0] BYTE_CRC3  = 6'd31;

    logic [23:0] r_crc,   n_crc;
    logic [5:0]  r_count, n_count;
    logic [23:0] r_rcv,   n_rcv;
    logic [5:0]  r_type,  n_type;
    logic [5:0]  r_slot,  n_slot;
    logic [11:0] r_corr,  n_corr;
    logic [3:0]  r_udrei, n_udrei;

    logic       w_acc;
    logic [7:0] w_d;

    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_d        = i_in.payload.data_byte;

    // Bytes 29..31 carry only the received CRC, so the 24 zero steps that
    // finish the computed CRC are spread over them, eight per byte.
    always_comb begin
        n_crc   = r_crc;
        n_count = r_count;
        n_rcv   = r_rcv;
        n_type  = r_type;
        n_slot  = r_slot;
        n_corr  = r_corr;
        n_udrei = r_udrei;
        if (r_count < FULL_BYTES) begin
            n_count = r_count + 6'd1;
            if (r_count <= BYTE_LAST_DATA) begin
                n_crc = crc_byte(r_crc, w_d);
            end else if (r_count == BYTE_CRC0) begin
                n_crc = crc_bit(crc_bit(r_crc, w_d[7]), w_d[6]);
                n_rcv[23:18] = w_d[5:0];
            end else begin
                n_crc = crc_byte(r_crc, 8'h00);
            end
            case (r_count)
                BYTE_TYPE: begin
                    n_type      = w_d[7:2];
                    n_slot[5:4] = w_d[1:0];
                end
                BYTE_SLOT:  n_slot[3:0]   = w_d[7:4];
                BYTE_CORR0: n_corr[11:10] = w_d[1:0];
                BYTE_CORR1: n_corr[9:2]   = w_d;
                BYTE_CORR2: begin
                    n_corr[1:0] = w_d[7:6];
                    n_udrei     = w_d[3:0];
                end
                BYTE_CRC1: n_rcv[17:10] = w_d;
                BYTE_CRC2: n_rcv[9:2]   = w_d;
                BYTE_CRC3: n_rcv[1:0]   = w_d[7:6];
                default: ;
            endcase
        end
    end

    assign o_q_push        = w_acc && i_in.payload.last_byte;
    assign o_q_job.is_short = (n_count != FULL_BYTES);
    assign o_q_job.crc_ok   = (n_crc == n_rcv);
    assign o_q_job.type_f   = n_type;
    assign o_q_job.slot_f   = n_slot;
    assign o_q_job.corr_f   = n_corr;
    assign o_q_job.udrei_f  = n_udrei;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= '0;
            r_count <= '0;
        end else if (w_acc) begin
            if (i_in.payload.last_byte) begin
                r_crc   <= '0;
                r_count <= '0;
            end else begin
                r_crc   <= n_crc;
                r_count <= n_count;
            end
        end
    end

    // Every field is rewritten before a full-length message can use it.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rcv   <= n_rcv;
            r_type  <= n_type;
            r_slot  <= n_slot;
            r_corr  <= n_corr;
            r_udrei <= n_udrei;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_BYTES)
        else $error("byte count beyond a full message");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.payload.last_byte) |=> (r_count == 6'd0 && r_crc == 24'd0))
        else $error("message state not cleared after last beat");

endmodule

[rtl/core/smcd_fifo.sv]
// Short queue of classified messages between the front end and the decoder.
module smcd_fifo
    import smcd_pkg::*;
#(
    parameter int DEPTH = 4
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue pushed while full or popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

[rtl/core/smcd_back.sv]
// Back end: turns a classified message into a result beat held in an output register.
module smcd_back
    import smcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_job          i_q_head,
    output logic          o_q_pop,
    smcd_stream_if.source o_out
);

    logic      r_valid;
    t_out_item r_item, n_item;
    logic      w_fc;
    logic      w_ok;

    assign o_q_pop = !i_q_empty && (!r_valid || o_out.ready);

    assign w_ok = !i_q_head.is_short && i_q_head.crc_ok;
    assign w_fc = w_ok && (i_q_head.type_f == TYPE_FC2 || i_q_head.type_f == TYPE_FC3 ||
                           i_q_head.type_f == TYPE_FC4 || i_q_head.type_f == TYPE_FC6);

    always_comb begin
        n_item = '0;
        if (i_q_head.is_short) begin
            n_item.status = STATUS_TOO_SHORT;
        end else if (!i_q_head.crc_ok) begin
            n_item.status = STATUS_CRC_FAIL;
        end else begin
            n_item.status   = STATUS_OK;
            n_item.msg_type = i_q_head.type_f;
        end
        if (w_fc) begin
            n_item.fc_valid       = 1'b1;
            n_item.sat_prn        = {2'b00, i_q_head.slot_f} + PRN_BASE;
            n_item.range_corr     = i_q_head.corr_f;
            n_item.udre_quarter_m = udre_lut(i_q_head.udrei_f);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= n_item;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.payload = r_item;

endmodule

[rtl/core/sbas_message_crc_check_and_decode.sv]
// Top level of the SBAS message CRC-24Q checker and fast-correction decoder.
// Accepts one message byte per clock, MSB first; the byte marked last yields one
// result beat (status, type, and for types 2, 3, 4 and 6 the PRN, range correction
// and UDRE in quarter meters). The front end updates the CRC with an 8-bit unrolled
// step per byte, so input throughput is one beat per cycle while the queue has room;
// a result beat passes through the queue and then the output register before it is
// valid at the output. Up to P_QUEUE_DEPTH finished results wait in a queue, plus one
// in the output register, while the output is stalled; input ready drops only when
// that queue is full. Bytes past the 32nd are ignored until one is marked last.
module sbas_message_crc_check_and_decode
    import smcd_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 4
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    smcd_stream_if.sink   i_in,
    smcd_stream_if.source o_out
);

    logic w_push, w_full, w_pop, w_empty;
    t_job w_job, w_head;

    smcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_q_push (w_push),
        .o_q_job  (w_job)
    );

    smcd_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    smcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_head  (w_head),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule
